/* sv/smu_pkg.sv */
// Package for the sensor value to micro units block.
// Holds the request and result types, format and status codes and the
// conversion constants. No dependencies.
`default_nettype none

package smu_pkg;

    // Format codes carried in the mode field
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_FLOAT = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    // Fixed point 22.10: multiplier 15625 = one million / 64
    localparam int          FIX_FRAC_BITS = 10;
    localparam logic [13:0] FIX_MULT      = 14'd15625;
    localparam logic [21:0] FIX_INT_MAX   = 22'd274877;

    // Single precision fields and limits
    localparam logic [31:0] FLT_INF      = 32'h7f800000;
    localparam logic [31:0] FLT_MAX_RAW  = 32'h4f800000;
    localparam logic [7:0]  FLT_EXP_ONES = 8'hff;
    localparam logic [19:0] FLT_SCALE    = 20'd1000000;
    // Right shift of mant*1e6*2^32 is 182 - biased exponent (127 + 23 + 32)
    localparam logic [8:0]  FLT_SHIFT_BASE = 9'd182;
    localparam logic [8:0]  FLT_WIDE_BITS  = 9'd76;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] raw_value;
    } smu_in_t;

    typedef struct packed {
        logic [31:0] scaled_value;
        logic [1:0]  status;
    } smu_out_t;

endpackage

`default_nettype wire

/* sv/smu_fixed_conv.sv */
// Unsigned 22.10 fixed point to micro units, with saturation.
// Combinational; uses smu_pkg.
`default_nettype none

module smu_fixed_conv (
    input  wire logic [31:0] raw_value,
    output smu_pkg::smu_out_t result
);

    logic [21:0] int_part;
    logic [9:0]  frac_part;
    logic [35:0] int_prod;
    logic [23:0] frac_prod;
    logic [32:0] sum;

    // Integer and fraction scaled separately, fraction truncated
    always_comb
    begin
        int_part  = raw_value[31:smu_pkg::FIX_FRAC_BITS];
        frac_part = raw_value[smu_pkg::FIX_FRAC_BITS-1:0];
        int_prod  = int_part * smu_pkg::FIX_MULT;
        frac_prod = frac_part * smu_pkg::FIX_MULT;
        sum       = int_prod[32:0] + {19'd0, frac_prod[23:smu_pkg::FIX_FRAC_BITS]};
        if (int_part > smu_pkg::FIX_INT_MAX || sum[32])
        begin
            result.scaled_value = '1;
            result.status       = smu_pkg::ST_SAT;
        end
        else
        begin
            result.scaled_value = sum[31:0];
            result.status       = smu_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

/* sv/smu_float_conv.sv */
// Single precision float to micro units, with invalid and saturation cases.
// Combinational; uses smu_pkg.
`default_nettype none

module smu_float_conv (
    input  wire logic [31:0] raw_value,
    output smu_pkg::smu_out_t result
);

    logic [7:0]  exp_field;
    logic [23:0] mant24;
    logic [43:0] prod;
    logic [75:0] wide;
    logic [8:0]  shift_amt;
    logic [75:0] shifted;

    always_comb
    begin
        exp_field = raw_value[30:23];
        // Hidden one is always set, denormals included
        mant24    = {1'b1, raw_value[22:0]};
        prod      = mant24 * smu_pkg::FLT_SCALE;
        // Pre-scale by 2^32 so one right shift covers every exponent
        wide      = {prod, 32'd0};
        shift_amt = smu_pkg::FLT_SHIFT_BASE - {1'b0, exp_field};
        shifted   = wide >> shift_amt[6:0];

        result.status       = smu_pkg::ST_OK;
        result.scaled_value = '0;
        if (raw_value[31])
        begin
            result.status = smu_pkg::ST_INVALID;
        end
        else if (raw_value == smu_pkg::FLT_INF)
        begin
            result.status       = smu_pkg::ST_SAT;
            result.scaled_value = '1;
        end
        else if (exp_field == smu_pkg::FLT_EXP_ONES)
        begin
            result.status = smu_pkg::ST_INVALID;
        end
        else if (raw_value == 32'd0)
        begin
            result.status = smu_pkg::ST_OK;
        end
        else if (raw_value > smu_pkg::FLT_MAX_RAW)
        begin
            result.status       = smu_pkg::ST_SAT;
            result.scaled_value = '1;
        end
        else if (shift_amt < smu_pkg::FLT_WIDE_BITS)
        begin
            // Exactly 2^32 keeps the wrapped low bits
            result.scaled_value = shifted[31:0];
        end
    end

endmodule

`default_nettype wire

/* sv/sensor_value_to_micro_units_unit.sv */
// Top level of the sensor value to micro units converter.
// Uses smu_pkg, smu_fixed_conv and smu_float_conv.
//
// Usage:
//   Requests arrive on in_valid/in_ready/in_data (mode, raw_value); each
//   request yields one result on out_valid/out_ready/out_data
//   (scaled_value, status).
//   Pass through returns raw_value; fixed mode reads 22.10; float mode reads
//   single precision, or 22.10 when fixed_format_capable is set.
//   cfg_wr_en/cfg_wr_data write fixed_format_capable; write it only while
//   no request is in flight.
//   Path: an accepted request lands in the input register, and the
//   conversion logic loads the result register from it once that
//   register is empty or being read out.
//   Throughput: one request per cycle while out_ready stays high; the
//   fixed point multipliers and the float multiply and barrel shift sit
//   in the single stage between the two registers.
//   Stall: while out_ready is low the result register holds, the input
//   register still takes one more request if empty, then in_ready drops.
//   Reset: rst_n clears both valid flags and fixed_format_capable.
`default_nettype none

module sensor_value_to_micro_units_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire smu_pkg::smu_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output smu_pkg::smu_out_t      out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data
);

    logic              cap_reg;
    logic              s1_valid_reg;
    smu_pkg::smu_in_t  s1_data_reg;
    logic              out_valid_reg;
    smu_pkg::smu_out_t out_data_reg;
    smu_pkg::smu_out_t out_data_next;
    smu_pkg::smu_out_t fixed_res;
    smu_pkg::smu_out_t float_res;
    logic              s1_adv;

    // Handshake: stage 1 moves when the result register is free
    assign s1_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Capability register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 1'b0;
        else if (cfg_wr_en)
            cap_reg <= cfg_wr_data;
    end

    // Conversion units
    smu_fixed_conv u_fixed (
        .raw_value (s1_data_reg.raw_value),
        .result    (fixed_res)
    );

    smu_float_conv u_float (
        .raw_value (s1_data_reg.raw_value),
        .result    (float_res)
    );

    // Format select; unused mode passes through
    always_comb
    begin
        case (s1_data_reg.mode)
            smu_pkg::MODE_FIXED: out_data_next = fixed_res;
            smu_pkg::MODE_FLOAT: out_data_next = cap_reg ? fixed_res : float_res;
            default:
            begin
                out_data_next.scaled_value = s1_data_reg.raw_value;
                out_data_next.status       = smu_pkg::ST_OK;
            end
        endcase
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (s1_adv && s1_valid_reg)
            out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted request lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted request not held in input register");

    // A moving request always reaches the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_adv |=> out_valid_reg)
        else $error("request lost between stages");

    // Invalid status carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status == smu_pkg::ST_INVALID
        |-> out_data_reg.scaled_value == 32'd0)
        else $error("invalid status with nonzero value");

    // Saturated status carries all ones, and no unused status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != smu_pkg::ST_OK
        && out_data_reg.status != smu_pkg::ST_INVALID
        |-> out_data_reg.status == smu_pkg::ST_SAT
        && out_data_reg.scaled_value == 32'hffffffff)
        else $error("bad saturated result");
`endif

endmodule

`default_nettype wire

/* bench/tb_sensor_value_to_micro_units_unit.sv */
// Testbench for sensor_value_to_micro_units_unit: directed and random requests
// checked against an in-bench predictor of the micro unit conversion.
// Depends on smu_pkg and the sensor_value_to_micro_units_unit RTL.
`default_nettype none

module tb_sensor_value_to_micro_units_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode 3 has no name in the package and is handled as pass through
    localparam logic [1:0]  MODE_SPARE    = 2'd3;
    localparam logic [63:0] MICRO_SCALE   = 64'd1000000;
    localparam logic [63:0] FRAC_MICRO    = 64'd15625;
    localparam logic [63:0] FRAC_DIV      = 64'd1024;
    localparam logic [63:0] INT_PART_MAX  = 64'd274877;
    localparam logic [63:0] WORD_MAX      = 64'hffffffff;
    localparam int          EXP_BIAS      = 127;
    localparam int          MANT_BITS     = 23;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          NUM_RANDOM    = 1000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    smu_pkg::smu_in_t  in_data     = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    smu_pkg::smu_out_t out_data;
    logic              cfg_wr_en   = 1'b0;
    logic              cfg_wr_data = 1'b0;

    // Bench state
    smu_pkg::smu_out_t pending_micro_q[$];
    logic     capable_shadow = 1'b0;
    int       mismatch_count = 0;
    bit       tx_idle_en     = 1'b1;
    bit       rx_idle_en     = 1'b1;
    int       rx_hold_request = 0;

    sensor_value_to_micro_units_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #1_000_000;
        $display("sensor_value_to_micro_units_unit verification failed");
        $finish;
    end

    // 22.10 fixed point to micro units, saturating
    function automatic smu_pkg::smu_out_t scale_fixed_22_10(logic [31:0] raw);
        smu_pkg::smu_out_t res;
        logic [63:0] int_part;
        logic [63:0] frac_part;
        logic [63:0] sum;
        int_part  = 64'(raw[31:10]);
        frac_part = 64'(raw[9:0]);
        sum       = int_part * FRAC_MICRO + (frac_part * FRAC_MICRO) / FRAC_DIV;
        if (int_part > INT_PART_MAX || sum > WORD_MAX)
            res = '{scaled_value: 32'hffffffff, status: smu_pkg::ST_SAT};
        else
            res = '{scaled_value: sum[31:0], status: smu_pkg::ST_OK};
        return res;
    endfunction

    // Expected result for one request under the given capability bit
    function automatic smu_pkg::smu_out_t predict_micro_units(logic [1:0] fmt,
                                                              logic [31:0] raw,
                                                              logic capable);
        smu_pkg::smu_out_t res;
        logic [63:0] prod;
        int          expo;
        res = '{scaled_value: raw, status: smu_pkg::ST_OK};
        if (fmt == smu_pkg::MODE_FIXED || (fmt == smu_pkg::MODE_FLOAT && capable))
            res = scale_fixed_22_10(raw);
        else if (fmt == smu_pkg::MODE_FLOAT)
        begin
            if (raw[31])
                res = '{scaled_value: '0, status: smu_pkg::ST_INVALID};
            else if (raw == smu_pkg::FLT_INF)
                res = '{scaled_value: 32'hffffffff, status: smu_pkg::ST_SAT};
            else if (raw[30:23] == smu_pkg::FLT_EXP_ONES)
                res = '{scaled_value: '0, status: smu_pkg::ST_INVALID};
            else if (raw == '0)
                res = '{scaled_value: '0, status: smu_pkg::ST_OK};
            else if (raw > smu_pkg::FLT_MAX_RAW)
                res = '{scaled_value: 32'hffffffff, status: smu_pkg::ST_SAT};
            else
            begin
                // hidden one is always set, denormals included
                expo = int'(raw[30:23]) - EXP_BIAS;
                prod = 64'({1'b1, raw[22:0]}) * MICRO_SCALE;
                if (expo < 0)
                    prod = (-expo >= 64) ? 64'd0 : prod >> (-expo);
                else
                    prod = prod << expo;
                prod = prod >> MANT_BITS;
                res  = '{scaled_value: prod[31:0], status: smu_pkg::ST_OK};
            end
        end
        return res;
    endfunction

    // Idle length: mostly none, often short, now and then long
    function automatic int next_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus long hold-offs requested by a test
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_request > 0)
            begin
                stall_left      = rx_hold_request;
                rx_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left -= 1;
            end
            else if (!rx_idle_en)
                out_ready <= 1'b1;
            else
            begin
                stall_left = next_gap();
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left -= 1;
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        smu_pkg::smu_out_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_micro_q.size() == 0)
            begin
                $error("unexpected result: scaled_value %h status %0d",
                       out_data.scaled_value, out_data.status);
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_micro_q.pop_front();
                if (out_data.scaled_value !== exp_res.scaled_value)
                begin
                    $error("scaled_value: expected %h, got %h",
                           exp_res.scaled_value, out_data.scaled_value);
                    mismatch_count++;
                end
                if (out_data.status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one request; returns right after the edge that accepted it
    task automatic send_request(input logic [1:0] fmt, input logic [31:0] raw);
        int gap;
        gap = tx_idle_en ? next_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{mode: fmt, raw_value: raw};
        do
            @(posedge clk);
        while (!in_ready);
        pending_micro_q.push_back(predict_micro_units(fmt, raw, capable_shadow));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        while (pending_micro_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Capability write; only called with nothing in flight
    task automatic write_capability(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        capable_shadow = value;
    endtask

    // Raw value for fixed point: mostly in range, some near the limit
    function automatic logic [31:0] pick_fixed_raw();
        int          pick;
        logic [21:0] int_part;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            int_part = 22'($urandom_range(0, 274877));
        else if (pick < 7)
            int_part = 22'($urandom_range(274874, 274880));
        else if (pick < 8)
            int_part = 22'($urandom_range(0, 15));
        else
            return $urandom;
        return {int_part, 10'($urandom)};
    endfunction

    // Raw value for float: mostly finite positive, plus specials and noise
    function automatic logic [31:0] pick_float_raw();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 8)
            return {1'b0, 8'($urandom_range(96, 158)), 23'($urandom)};
        else if (pick < 9)
            return {1'b0, 8'($urandom_range(0, 95)), 23'($urandom)};
        else if (pick < 10)
            return {1'b0, 8'd159, ($urandom_range(0, 1) == 0) ? 23'd0 : 23'($urandom)};
        else if (pick < 11)
        begin
            case ($urandom_range(0, 3))
                0: return smu_pkg::FLT_INF;
                1: return {1'b0, smu_pkg::FLT_EXP_ONES, 23'($urandom_range(1, 8388607))};
                2: return 32'h0;
                default: return 32'h80000000;
            endcase
        end
        else if (pick < 12)
            return {1'b1, 31'($urandom)};
        else
            return $urandom;
    endfunction

    // One random request over all modes
    task automatic send_random_request();
        int         pick;
        logic [1:0] fmt;
        logic [31:0] raw;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            fmt = ($urandom_range(0, 3) == 0) ? MODE_SPARE : smu_pkg::MODE_PASS;
            raw = $urandom;
        end
        else if (pick < 5)
        begin
            fmt = smu_pkg::MODE_FIXED;
            raw = pick_fixed_raw();
        end
        else
        begin
            fmt = smu_pkg::MODE_FLOAT;
            raw = ($urandom_range(0, 3) == 0) ? pick_fixed_raw() : pick_float_raw();
        end
        send_request(fmt, raw);
    endtask

    // Field extremes and each conversion corner, capability clear
    task automatic test_directed_corners();
        send_request(smu_pkg::MODE_PASS, 32'h00000000);
        send_request(smu_pkg::MODE_PASS, 32'hffffffff);
        send_request(MODE_SPARE, 32'h5a5a5a5a);
        send_request(MODE_SPARE, 32'ha5a5a5a5);
        // fixed: zero, fraction only, the largest integer part, overflow by fraction
        send_request(smu_pkg::MODE_FIXED, 32'h00000000);
        send_request(smu_pkg::MODE_FIXED, 32'h000003ff);
        send_request(smu_pkg::MODE_FIXED, {22'd274877, 10'd0});
        send_request(smu_pkg::MODE_FIXED, {22'd274877, 10'd928});
        send_request(smu_pkg::MODE_FIXED, {22'd274877, 10'd929});
        send_request(smu_pkg::MODE_FIXED, {22'd274878, 10'd0});
        send_request(smu_pkg::MODE_FIXED, 32'hffffffff);
        // float: signs, infinity, NaNs, zero, range limits, denormals
        send_request(smu_pkg::MODE_FLOAT, 32'h80000000);
        send_request(smu_pkg::MODE_FLOAT, 32'hbf800000);
        send_request(smu_pkg::MODE_FLOAT, smu_pkg::FLT_INF);
        send_request(smu_pkg::MODE_FLOAT, 32'h7fc00000);
        send_request(smu_pkg::MODE_FLOAT, 32'h7f800001);
        send_request(smu_pkg::MODE_FLOAT, 32'h00000000);
        send_request(smu_pkg::MODE_FLOAT, smu_pkg::FLT_MAX_RAW);
        send_request(smu_pkg::MODE_FLOAT, 32'h4f800001);
        send_request(smu_pkg::MODE_FLOAT, 32'h4f7fffff);
        send_request(smu_pkg::MODE_FLOAT, 32'h3f800000);
        send_request(smu_pkg::MODE_FLOAT, 32'h3f000000);
        send_request(smu_pkg::MODE_FLOAT, 32'h00000001);
        send_request(smu_pkg::MODE_FLOAT, 32'h00400000);
        drain_results(SETTLE_CYCLES);
    endtask

    // Float mode read as fixed point once the capability bit is set
    task automatic test_capability_fixed();
        write_capability(1'b1);
        send_request(smu_pkg::MODE_FLOAT, {22'd274877, 10'd929});
        send_request(smu_pkg::MODE_FLOAT, smu_pkg::FLT_INF);
        repeat (58) send_random_request();
        drain_results(SETTLE_CYCLES);
    endtask

    // Random mix, capability toggled per phase, one full sender pause
    task automatic test_random_mix();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_capability(phase[0]);
            for (int n = 0; n < NUM_RANDOM / 4; n++)
            begin
                send_random_request();
                if (phase == 1 && n == NUM_RANDOM / 8)
                    drain_results(0);
            end
            drain_results(SETTLE_CYCLES);
        end
    endtask

    // Receiver holds off long while requests keep coming back to back
    task automatic test_output_backpressure();
        tx_idle_en      = 1'b0;
        rx_hold_request = 120;
        repeat (60) send_random_request();
        drain_results(SETTLE_CYCLES);
    endtask

    // Full rate on both sides
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (200) send_random_request();
        drain_results(SETTLE_CYCLES);
    endtask

    // Sequence of tests
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_capability_fixed();
        test_random_mix();
        test_output_backpressure();
        test_full_rate();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_micro_q.size() == 0)
            $display("sensor_value_to_micro_units_unit verification clean");
        else
            $display("sensor_value_to_micro_units_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
